// ===== src/hybla_cwnd_update_unit_macros.svh =====
// Assertion macros for the Hybla congestion window update unit.
`ifndef HYBLA_CWND_UPDATE_UNIT_MACROS_SVH
`define HYBLA_CWND_UPDATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off while rst_n is low
`define HYBLA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define HYBLA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HYBLA_ASSERT_IMP(name, ante, cons, msg)

`define HYBLA_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// ===== src/hybla_pkg.sv =====
// Shared types, constants and the power-of-two fraction table for the Hybla unit.
package hybla_pkg;

    // Datapath and register widths
    localparam int DATA_W       = 32;
    localparam int CFG_W        = 16;
    localparam int FRAC_ACC_W   = 8;
    localparam int SUB_SEG_W    = 7;     // window steps carried in 1/128 segment
    localparam int RHO_FRAC_W   = 3;     // rho held in eighths
    localparam int SHIFT_W      = 5;
    localparam int IN_TDATA_W   = 72;
    localparam int OUT_TDATA_W  = 72;

    // Fixed constants of the window rule
    localparam int FRACTION_TABLE_DEPTH = 8;
    localparam int MAX_SHIFT            = 16;
    localparam int ONE_SEGMENT          = 128;
    localparam int RHO_MIN              = 8;
    localparam int CFG_REF_RTT_RESET    = 25;
    localparam int CFG_CLAMP_RESET      = 65535;

    // Item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ACK   = 2'd1,
        OP_STATE = 2'd2
    } opcode_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_REF_RTT = 1'b0,
        CFG_CLAMP   = 1'b1
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MDIV,
        S_MUL,
        S_GROW,
        S_CADIV,
        S_APPLY_ADD,
        S_APPLY_BUMP,
        S_APPLY_SS,
        S_APPLY_CLAMP,
        S_OUT
    } state_t;

    // 2^(k/8) in 1/128 units
    function automatic logic [7:0] pow2_frac(input logic [RHO_FRAC_W-1:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'd128;
            3'd1:    val = 8'd139;
            3'd2:    val = 8'd152;
            3'd3:    val = 8'd165;
            3'd4:    val = 8'd181;
            3'd5:    val = 8'd197;
            3'd6:    val = 8'd215;
            3'd7:    val = 8'd234;
            default: val = 8'd128;
        endcase
        return val;
    endfunction

endpackage

// ===== src/hybla_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module hybla_div #(
    parameter int WIDTH = hybla_pkg::DATA_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Next state of the iteration
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/hybla_cwnd_update_unit.sv =====
// Top level of the Hybla congestion window update unit: sequencer and window datapath.
//
// One flow's Hybla window state. Items arrive on the s_axis channel: tuser
// carries the item kind (init, ack, state change), tdata the RTT, ssthresh
// and flags. Each item gives exactly one result transfer on m_axis with the
// window, the slow start and Reno fallback flags and rho in eighths.
// Configuration (reference RTT, window clamp) is written through cfg_wr_en,
// cfg_index and cfg_data; the user must write it only while no item is in
// flight, as the block itself does not enforce this. A rho measurement and
// a congestion avoidance step each take one pass through the shared
// divider. The input is ready only while the sequencer is idle, so a new
// item is accepted only after the previous one has been handed to the
// output register.
// Results sit in an output register: the next item is accepted while a result
// waits, and a stalled receiver holds the sequencer in its output state only
// once the following result is ready.
// Reset clears the window state to zero, loads the configuration defaults and
// empties the output register.
`include "hybla_cwnd_update_unit_macros.svh"

module hybla_cwnd_update_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] smoothed_rtt, [32] window_limited, [64:33] slow_start_threshold,
    // [65] state_open, [71:66] zero
    input  logic [hybla_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                         s_axis_tuser,
    // Results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] window, [32] in_slow_start, [33] reno_fallback, [65:34] rho_eighths,
    // [71:66] zero
    output logic [hybla_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [hybla_pkg::CFG_W-1:0]        cfg_data
);

    localparam int DW = hybla_pkg::DATA_W;

    hybla_pkg::state_t state_reg, state_next;

    // Latched input item
    logic [1:0]                        opcode_reg, opcode_next;
    logic [DW-1:0]                     srtt_reg, srtt_next;
    logic                              limited_reg, limited_next;
    logic [DW-1:0]                     ssthresh_reg, ssthresh_next;
    logic                              open_reg, open_next;

    // Configuration
    logic [hybla_pkg::CFG_W-1:0]       ref_rtt_reg, ref_rtt_next;
    logic [hybla_pkg::CFG_W-1:0]       clamp_reg, clamp_next;

    // Flow state
    logic                              enabled_reg, enabled_next;
    logic [DW-1:0]                     cwnd_reg, cwnd_next;
    logic [DW-1:0]                     gc_reg, gc_next;
    logic [hybla_pkg::FRAC_ACC_W-1:0]  frac_acc_reg, frac_acc_next;
    logic [DW-1:0]                     rho_reg, rho_next;
    logic [DW-1:0]                     rho_sq_reg, rho_sq_next;
    logic [DW-1:0]                     lowest_reg, lowest_next;

    // Per-item working values
    logic [DW-1:0]                     inc_reg, inc_next;
    logic                              slow_reg, slow_next;
    logic                              reno_reg, reno_next;

    // Output register
    logic                                 out_valid_reg, out_valid_next;
    logic [hybla_pkg::OUT_TDATA_W-1:0]    out_data_reg, out_data_next;

    // Shared divider
    logic                              div_start;
    logic [DW-1:0]                     div_dividend;
    logic [DW-1:0]                     div_divisor;
    logic                              div_busy;
    logic                              div_done;
    logic [DW-1:0]                     div_quo;

    // Datapath helpers
    logic [DW-1:0]                     ref_div;
    logic [DW-1:0]                     cwnd_div;
    logic [DW-1:0]                     sq_lo;
    logic [hybla_pkg::SHIFT_W-1:0]     ss_shift;
    logic [DW-1:0]                     ss_inc;
    logic [hybla_pkg::FRAC_ACC_W-1:0]  frac_sum;
    logic [DW-1:0]                     clamp_ext;

    hybla_div #(
        .WIDTH (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Divisors with zero read as one
    assign ref_div  = (ref_rtt_reg == '0) ? DW'(1) : {{(DW - hybla_pkg::CFG_W){1'b0}}, ref_rtt_reg};
    assign cwnd_div = (cwnd_reg == '0) ? DW'(1) : cwnd_reg;

    // Low word of rho squared
    assign sq_lo = rho_reg * rho_reg;

    // Slow start step: 2^rho in 1/128 units, less one segment
    assign ss_shift = (rho_reg[DW-1:hybla_pkg::RHO_FRAC_W] < (DW - hybla_pkg::RHO_FRAC_W)'(hybla_pkg::MAX_SHIFT))
                    ? rho_reg[hybla_pkg::RHO_FRAC_W +: hybla_pkg::SHIFT_W]
                    : hybla_pkg::SHIFT_W'(hybla_pkg::MAX_SHIFT);
    assign ss_inc   = ({{(DW - 8){1'b0}}, hybla_pkg::pow2_frac(rho_reg[hybla_pkg::RHO_FRAC_W-1:0])}
                       << ss_shift) - DW'(hybla_pkg::ONE_SEGMENT);

    // Sub-segment accumulation, bit 7 is the carry into the window
    assign frac_sum  = frac_acc_reg + {1'b0, inc_reg[hybla_pkg::SUB_SEG_W-1:0]};
    assign clamp_ext = {{(DW - hybla_pkg::CFG_W){1'b0}}, clamp_reg};

    assign s_axis_tready = (state_reg == hybla_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration writes
    always_comb
    begin
        ref_rtt_next = ref_rtt_reg;
        clamp_next   = clamp_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                hybla_pkg::CFG_REF_RTT: ref_rtt_next = cfg_data;
                hybla_pkg::CFG_CLAMP:   clamp_next   = cfg_data;
                default:                ref_rtt_next = ref_rtt_reg;
            endcase
        end
    end

    // Sequencer and window update
    always_comb
    begin
        state_next     = state_reg;
        opcode_next    = opcode_reg;
        srtt_next      = srtt_reg;
        limited_next   = limited_reg;
        ssthresh_next  = ssthresh_reg;
        open_next      = open_reg;
        enabled_next   = enabled_reg;
        cwnd_next      = cwnd_reg;
        gc_next        = gc_reg;
        frac_acc_next  = frac_acc_reg;
        rho_next       = rho_reg;
        rho_sq_next    = rho_sq_reg;
        lowest_next    = lowest_reg;
        inc_next       = inc_reg;
        slow_next      = slow_reg;
        reno_next      = reno_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        div_start      = 1'b0;
        div_dividend   = srtt_reg;
        div_divisor    = ref_div;

        case (state_reg)
            hybla_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    opcode_next   = s_axis_tuser;
                    srtt_next     = s_axis_tdata[31:0];
                    limited_next  = s_axis_tdata[32];
                    ssthresh_next = s_axis_tdata[64:33];
                    open_next     = s_axis_tdata[65];
                    state_next    = hybla_pkg::S_DECODE;
                end
            end

            hybla_pkg::S_DECODE:
            begin
                slow_next = 1'b0;
                reno_next = 1'b0;
                case (opcode_reg)
                    hybla_pkg::OP_INIT:
                    begin
                        lowest_next = srtt_reg;
                        div_start   = 1'b1;
                        state_next  = hybla_pkg::S_MDIV;
                    end
                    hybla_pkg::OP_ACK:
                    begin
                        // new minimum RTT: re-measure rho
                        if (srtt_reg < lowest_reg)
                        begin
                            lowest_next = srtt_reg;
                            div_start   = 1'b1;
                            state_next  = hybla_pkg::S_MDIV;
                        end
                        else
                        begin
                            state_next = hybla_pkg::S_GROW;
                        end
                    end
                    hybla_pkg::OP_STATE:
                    begin
                        enabled_next = open_reg;
                        state_next   = hybla_pkg::S_OUT;
                    end
                    default:
                    begin
                        state_next = hybla_pkg::S_OUT;
                    end
                endcase
            end

            // rho = srtt / reference, floored at one segment
            hybla_pkg::S_MDIV:
            begin
                if (div_done)
                begin
                    rho_next   = (div_quo < DW'(hybla_pkg::RHO_MIN)) ? DW'(hybla_pkg::RHO_MIN)
                                                                     : div_quo;
                    state_next = hybla_pkg::S_MUL;
                end
            end

            hybla_pkg::S_MUL:
            begin
                rho_sq_next = {sq_lo[DW-2:0], 1'b0};
                if (opcode_reg == hybla_pkg::OP_INIT)
                begin
                    enabled_next  = 1'b1;
                    frac_acc_next = '0;
                    cwnd_next     = {{hybla_pkg::RHO_FRAC_W{1'b0}}, rho_reg[DW-1:hybla_pkg::RHO_FRAC_W]};
                    state_next    = hybla_pkg::S_OUT;
                end
                else
                begin
                    state_next = hybla_pkg::S_GROW;
                end
            end

            hybla_pkg::S_GROW:
            begin
                if (!limited_reg)
                begin
                    state_next = hybla_pkg::S_OUT;
                end
                else if (!enabled_reg)
                begin
                    reno_next  = 1'b1;
                    state_next = hybla_pkg::S_OUT;
                end
                else if (rho_reg[DW-1:hybla_pkg::RHO_FRAC_W] == '0)
                begin
                    // rho never measured: measure it now
                    div_start  = 1'b1;
                    state_next = hybla_pkg::S_MDIV;
                end
                else if (cwnd_reg < ssthresh_reg)
                begin
                    slow_next  = 1'b1;
                    inc_next   = ss_inc;
                    state_next = hybla_pkg::S_APPLY_ADD;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = rho_sq_reg;
                    div_divisor  = cwnd_div;
                    state_next   = hybla_pkg::S_CADIV;
                end
            end

            // congestion avoidance step rho^2 / cwnd
            hybla_pkg::S_CADIV:
            begin
                div_dividend = rho_sq_reg;
                div_divisor  = cwnd_div;
                if (div_done)
                begin
                    inc_next = div_quo;
                    if (div_quo < DW'(hybla_pkg::ONE_SEGMENT))
                    begin
                        gc_next = gc_reg + 1'b1;
                    end
                    state_next = hybla_pkg::S_APPLY_ADD;
                end
            end

            // whole segments plus carry out of the fraction
            hybla_pkg::S_APPLY_ADD:
            begin
                cwnd_next     = cwnd_reg + {{hybla_pkg::SUB_SEG_W{1'b0}}, inc_reg[DW-1:hybla_pkg::SUB_SEG_W]}
                              + {{(DW - 1){1'b0}}, frac_sum[hybla_pkg::SUB_SEG_W]};
                frac_acc_next = {1'b0, frac_sum[hybla_pkg::SUB_SEG_W-1:0]};
                if (frac_sum[hybla_pkg::SUB_SEG_W])
                begin
                    gc_next = '0;
                end
                state_next = hybla_pkg::S_APPLY_BUMP;
            end

            // zero step: grow once per window of acks
            hybla_pkg::S_APPLY_BUMP:
            begin
                if (inc_reg == '0 && gc_reg >= cwnd_reg)
                begin
                    cwnd_next = cwnd_reg + 1'b1;
                    gc_next   = '0;
                end
                state_next = hybla_pkg::S_APPLY_SS;
            end

            hybla_pkg::S_APPLY_SS:
            begin
                if (slow_reg && cwnd_reg > ssthresh_reg)
                begin
                    cwnd_next = ssthresh_reg;
                end
                state_next = hybla_pkg::S_APPLY_CLAMP;
            end

            hybla_pkg::S_APPLY_CLAMP:
            begin
                if (cwnd_reg > clamp_ext)
                begin
                    cwnd_next = clamp_ext;
                end
                state_next = hybla_pkg::S_OUT;
            end

            // hand the result to the output register once it is free
            hybla_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {{(hybla_pkg::OUT_TDATA_W - 2 * DW - 2){1'b0}},
                                      rho_reg, reno_reg, slow_reg, cwnd_reg};
                    out_valid_next = 1'b1;
                    state_next     = hybla_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hybla_pkg::S_IDLE;
            end
        endcase
    end

    // Control and flow state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hybla_pkg::S_IDLE;
            ref_rtt_reg   <= hybla_pkg::CFG_W'(hybla_pkg::CFG_REF_RTT_RESET);
            clamp_reg     <= hybla_pkg::CFG_W'(hybla_pkg::CFG_CLAMP_RESET);
            enabled_reg   <= 1'b0;
            cwnd_reg      <= '0;
            gc_reg        <= '0;
            frac_acc_reg  <= '0;
            rho_reg       <= '0;
            rho_sq_reg    <= '0;
            lowest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_rtt_reg   <= ref_rtt_next;
            clamp_reg     <= clamp_next;
            enabled_reg   <= enabled_next;
            cwnd_reg      <= cwnd_next;
            gc_reg        <= gc_next;
            frac_acc_reg  <= frac_acc_next;
            rho_reg       <= rho_next;
            rho_sq_reg    <= rho_sq_next;
            lowest_reg    <= lowest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        opcode_reg   <= opcode_next;
        srtt_reg     <= srtt_next;
        limited_reg  <= limited_next;
        ssthresh_reg <= ssthresh_next;
        open_reg     <= open_next;
        inc_reg      <= inc_next;
        slow_reg     <= slow_next;
        reno_reg     <= reno_next;
        out_data_reg <= out_data_next;
    end

    // Checks
    `HYBLA_ASSERT_IMP(a_frac_below_segment, state_reg == hybla_pkg::S_IDLE, frac_acc_reg < 8'd128, "fraction accumulator reached a whole segment")
    `HYBLA_ASSERT_IMP(a_div_start_free, div_start, !div_busy, "divider started while busy")
    `HYBLA_ASSERT_IMP(a_div_done_awaited, div_done, state_reg == hybla_pkg::S_MDIV || state_reg == hybla_pkg::S_CADIV, "divider result not awaited")
    `HYBLA_ASSERT_IMP(a_rho_floor, state_reg == hybla_pkg::S_MUL, rho_reg >= 32'd8, "measured rho below one segment")
    `HYBLA_ASSERT_NXT(a_result_loaded, state_reg == hybla_pkg::S_OUT && (!out_valid_reg || m_axis_tready), out_valid_reg && state_reg == hybla_pkg::S_IDLE, "result not loaded into output register")

endmodule
